FILE: rtl/hpm_pkg.sv
`default_nettype none
package hpm_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int COORD_FRAC_DEF  = 16;
	localparam int COEF_WIDTH      = 32;
	localparam int COEF_FRAC       = 16;
	localparam int PERSP_FRAC      = 31;
	localparam int CFG_DATA_W      = 64;
	localparam int CFG_ADDR_W      = 6;

	localparam logic [63:0] ROW0_RST  = 64'h0001_0000_0000_0000;
	localparam logic [63:0] ROW1_RST  = 64'h0000_0000_0001_0000;
	localparam logic [63:0] TRANS_RST = 64'h0;
	localparam logic [63:0] PERSP_RST = 64'h0;
	localparam logic [31:0] SCALE_RST = 32'h0001_0000;

	typedef enum logic [2:0] {
		REG_ROW0  = 3'd0,
		REG_ROW1  = 3'd1,
		REG_TRANS = 3'd2,
		REG_PERSP = 3'd3,
		REG_SCALE = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic vld;
		logic neg0;
		logic neg1;
		logic ovf0;
		logic ovf1;
		logic zero;
	} div_ctrl_t;

endpackage
`default_nettype wire

FILE: rtl/hpm_div_stage.sv
`default_nettype none
module hpm_div_stage #(
	parameter int RW  = 97,
	parameter int DW  = 66,
	parameter int QW  = 32,
	parameter int BIT = 0
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire hpm_pkg::div_ctrl_t  ctrl_i,
	input  wire logic [RW-1:0]       r0_i,
	input  wire logic [RW-1:0]       r1_i,
	input  wire logic [DW-1:0]       d_i,
	input  wire logic [QW-1:0]       q0_i,
	input  wire logic [QW-1:0]       q1_i,
	output hpm_pkg::div_ctrl_t       ctrl_o,
	output logic [RW-1:0]            r0_o,
	output logic [RW-1:0]            r1_o,
	output logic [DW-1:0]            d_o,
	output logic [QW-1:0]            q0_o,
	output logic [QW-1:0]            q1_o
);
	import hpm_pkg::*;

	localparam int EW = RW + QW + DW;

	logic [EW-1:0] dsh;
	logic [EW-1:0] r0e;
	logic [EW-1:0] r1e;
	logic          ge0;
	logic          ge1;
	div_ctrl_t     ctrl_s;
	logic [RW-1:0] r0_s;
	logic [RW-1:0] r1_s;
	logic [DW-1:0] d_s;
	logic [QW-1:0] q0_s;
	logic [QW-1:0] q1_s;

	assign dsh = EW'(d_i) << BIT;
	assign r0e = EW'(r0_i);
	assign r1e = EW'(r1_i);
	assign ge0 = r0e >= dsh;
	assign ge1 = r1e >= dsh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s <= '0;
		end else if (en) begin
			ctrl_s <= ctrl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r0_s <= ge0 ? RW'(r0e - dsh) : r0_i;
			r1_s <= ge1 ? RW'(r1e - dsh) : r1_i;
			d_s  <= d_i;
			q0_s <= q0_i | (QW'(ge0) << BIT);
			q1_s <= q1_i | (QW'(ge1) << BIT);
		end
	end

	assign ctrl_o = ctrl_s;
	assign r0_o   = r0_s;
	assign r1_o   = r1_s;
	assign d_o    = d_s;
	assign q0_o   = q0_s;
	assign q1_o   = q1_s;

endmodule
`default_nettype wire

FILE: rtl/homography_point_mapper.sv
// Homography point mapper: (x,y) -> (z0/z2, z1/z2) in signed fixed point.
// Pipeline: multiply, sum, magnitude/overflow check, one quotient bit per stage,
// then saturate.
// Throughput: one point per cycle; the whole pipeline holds while the output stalls.
// Reset: asynchronous, active low; clears valid bits and loads the identity transform.
`default_nettype none
module homography_point_mapper #(
	parameter int COORD_WIDTH = hpm_pkg::COORD_WIDTH_DEF,
	parameter int COORD_FRAC  = hpm_pkg::COORD_FRAC_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  s_axis_tvalid,
	output logic                                       s_axis_tready,
	// src_x, src_y
	input  wire logic [((2*COORD_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
	output logic                                       m_axis_tvalid,
	input  wire logic                                  m_axis_tready,
	// dst_x, dst_y
	output logic [((2*COORD_WIDTH+7)/8)*8-1:0]         m_axis_tdata,
	// denom_zero, saturated
	output logic [1:0]                                 m_axis_tuser,
	input  wire logic                                  psel,
	input  wire logic                                  penable,
	input  wire logic                                  pwrite,
	input  wire logic [hpm_pkg::CFG_ADDR_W-1:0]        paddr,
	input  wire logic [hpm_pkg::CFG_DATA_W-1:0]        pwdata,
	output logic [hpm_pkg::CFG_DATA_W-1:0]             prdata,
	output logic                                       pready
);
	import hpm_pkg::*;

	localparam int CW   = COORD_WIDTH;
	localparam int TDW  = ((2*CW+7)/8)*8;
	localparam int PW   = COEF_WIDTH + CW;
	localparam int SH   = PERSP_FRAC + COORD_FRAC - COEF_FRAC;
	localparam int ZW   = ((PW > COEF_WIDTH + SH) ? PW : COEF_WIDTH + SH) + 2;
	localparam int RW   = ZW + SH;
	localparam int DW   = ZW;
	localparam int EW   = RW + CW;

	logic [63:0] row0_q, row1_q, trans_q, persp_q;
	logic [31:0] scale_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row0_q  <= ROW0_RST;
			row1_q  <= ROW1_RST;
			trans_q <= TRANS_RST;
			persp_q <= PERSP_RST;
			scale_q <= SCALE_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx_t'(paddr[5:3]))
				REG_ROW0:  row0_q  <= pwdata;
				REG_ROW1:  row1_q  <= pwdata;
				REG_TRANS: trans_q <= pwdata;
				REG_PERSP: persp_q <= pwdata;
				REG_SCALE: scale_q <= pwdata[31:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[5:3]))
			REG_ROW0:  prdata = row0_q;
			REG_ROW1:  prdata = row1_q;
			REG_TRANS: prdata = trans_q;
			REG_PERSP: prdata = persp_q;
			REG_SCALE: prdata = {32'h0, scale_q};
			default:   prdata = '0;
		endcase
	end

	logic signed [COEF_WIDTH-1:0] h00, h01, h02, h10, h11, h12, h20, h21, h22;
	logic signed [CW-1:0]         x_in, y_in;
	logic                         adv;
	logic                         out_vld_q;

	assign h00  = row0_q[63:32];
	assign h01  = row0_q[31:0];
	assign h10  = row1_q[63:32];
	assign h11  = row1_q[31:0];
	assign h02  = trans_q[63:32];
	assign h12  = trans_q[31:0];
	assign h20  = persp_q[63:32];
	assign h21  = persp_q[31:0];
	assign h22  = scale_q;
	assign x_in = s_axis_tdata[CW-1:0];
	assign y_in = s_axis_tdata[2*CW-1:CW];

	assign adv           = !out_vld_q || m_axis_tready;
	assign s_axis_tready = adv;

	// stage 1: products
	logic                 vld_s1;
	logic signed [PW-1:0] p00_s1, p01_s1, p10_s1, p11_s1, p20_s1, p21_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p00_s1 <= h00 * x_in;
			p01_s1 <= h01 * y_in;
			p10_s1 <= h10 * x_in;
			p11_s1 <= h11 * y_in;
			p20_s1 <= h20 * x_in;
			p21_s1 <= h21 * y_in;
		end
	end

	// stage 2: sums
	logic                 vld_s2;
	logic signed [ZW-1:0] z0_s2, z1_s2, z2_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			z0_s2 <= ZW'(p00_s1) + ZW'(p01_s1) + (ZW'(h02) <<< COORD_FRAC);
			z1_s2 <= ZW'(p10_s1) + ZW'(p11_s1) + (ZW'(h12) <<< COORD_FRAC);
			z2_s2 <= ZW'(p20_s1) + ZW'(p21_s1) + (ZW'(h22) <<< SH);
		end
	end

	// stage 3: magnitudes, signs, overflow
	logic [ZW-1:0] mag0, mag1, magd;
	logic [RW-1:0] n0, n1;
	logic [EW-1:0] dlim;

	assign mag0 = z0_s2[ZW-1] ? ZW'(-z0_s2) : z0_s2;
	assign mag1 = z1_s2[ZW-1] ? ZW'(-z1_s2) : z1_s2;
	assign magd = z2_s2[ZW-1] ? ZW'(-z2_s2) : z2_s2;
	assign n0   = {mag0, {SH{1'b0}}};
	assign n1   = {mag1, {SH{1'b0}}};
	assign dlim = EW'(magd) << CW;

	div_ctrl_t     ctrl_s3;
	logic [RW-1:0] r0_s3, r1_s3;
	logic [DW-1:0] d_s3;

	div_ctrl_t     ctrl_c [0:CW];
	logic [RW-1:0] r0_c   [0:CW];
	logic [RW-1:0] r1_c   [0:CW];
	logic [DW-1:0] d_c    [0:CW];
	logic [CW-1:0] q0_c   [0:CW];
	logic [CW-1:0] q1_c   [0:CW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s3 <= '0;
		end else if (adv) begin
			ctrl_s3.vld  <= vld_s2;
			ctrl_s3.neg0 <= z0_s2[ZW-1] != z2_s2[ZW-1];
			ctrl_s3.neg1 <= z1_s2[ZW-1] != z2_s2[ZW-1];
			ctrl_s3.ovf0 <= EW'(n0) >= dlim;
			ctrl_s3.ovf1 <= EW'(n1) >= dlim;
			ctrl_s3.zero <= z2_s2 == '0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			r0_s3 <= n0;
			r1_s3 <= n1;
			d_s3  <= magd;
		end
	end

	assign ctrl_c[0] = ctrl_s3;
	assign r0_c[0]   = r0_s3;
	assign r1_c[0]   = r1_s3;
	assign d_c[0]    = d_s3;
	assign q0_c[0]   = '0;
	assign q1_c[0]   = '0;

	// quotient bits, most significant first
	for (genvar k = 0; k < CW; k++) begin : g_div
		hpm_div_stage #(
			.RW  (RW),
			.DW  (DW),
			.QW  (CW),
			.BIT (CW - 1 - k)
		) u_stage (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.ctrl_i (ctrl_c[k]),
			.r0_i   (r0_c[k]),
			.r1_i   (r1_c[k]),
			.d_i    (d_c[k]),
			.q0_i   (q0_c[k]),
			.q1_i   (q1_c[k]),
			.ctrl_o (ctrl_c[k+1]),
			.r0_o   (r0_c[k+1]),
			.r1_o   (r1_c[k+1]),
			.d_o    (d_c[k+1]),
			.q0_o   (q0_c[k+1]),
			.q1_o   (q1_c[k+1])
		);
	end

	// output stage: sign, saturate, zero on zero denominator
	localparam logic [CW-1:0] LIM_POS = {1'b0, {(CW-1){1'b1}}};
	localparam logic [CW-1:0] LIM_NEG = {1'b1, {(CW-1){1'b0}}};

	div_ctrl_t     fin;
	logic [CW-1:0] qa, qb, la, lb, ma, mb, va, vb;
	logic          sa, sb;
	logic [CW-1:0] dst_x_q, dst_y_q;
	logic          dz_q, sat_q;

	assign fin = ctrl_c[CW];
	assign qa  = q0_c[CW];
	assign qb  = q1_c[CW];

	always_comb begin
		la = fin.neg0 ? LIM_NEG : LIM_POS;
		lb = fin.neg1 ? LIM_NEG : LIM_POS;
		sa = fin.ovf0 || (qa > la);
		sb = fin.ovf1 || (qb > lb);
		ma = sa ? la : qa;
		mb = sb ? lb : qb;
		va = fin.neg0 ? CW'(-ma) : ma;
		vb = fin.neg1 ? CW'(-mb) : mb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= fin.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dst_x_q <= fin.zero ? '0 : va;
			dst_y_q <= fin.zero ? '0 : vb;
			dz_q    <= fin.zero;
			sat_q   <= !fin.zero && (sa || sb);
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = TDW'({dst_y_q, dst_x_q});
	assign m_axis_tuser  = {sat_q, dz_q};

	a_zero_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && dz_q |-> dst_x_q == '0 && dst_y_q == '0)
		else $error("zero denominator with nonzero result");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> !(dz_q && sat_q))
		else $error("denom_zero and saturated both set");

	a_enter_s1: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> vld_s1)
		else $error("transfer did not reach stage 1");

endmodule
`default_nettype wire
